// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl of the auto-gain compressor
// no dependencies; the assertion bodies drop out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AAGC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define AAGC_ASSERT_NEVER(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("forbidden condition seen");
`else
`define AAGC_ASSERT(name, clk, rst_n, prop)
`define AAGC_ASSERT_NEVER(name, clk, rst_n, prop)
`endif

`endif

// ===== hw/rtl/aagc_pkg.sv =====
// shared types and constants of the ambisonic auto-gain compressor
// no dependencies
package aagc_pkg;

  localparam int unsigned SmpW    = 16;
  localparam int unsigned GainW   = 24;
  localparam int unsigned StepW   = 23;
  localparam int unsigned CfgIdxW = 2;

  // unsigned q2.22 constants
  localparam logic [GainW-1:0] OneQ22  = 24'd4194304;
  localparam logic [GainW-1:0] GainMin = 24'd2097152;
  localparam logic [GainW-1:0] GainMax = 24'd8388608;

  // 2^44 / g: the dividend bits above the 24 quotient bits, i.e. 2^20
  localparam logic [GainW-1:0] RemInit  = 24'd1048576;
  localparam int unsigned      DivSteps = 24;

  localparam logic [StepW-1:0] AttackRst  = 23'd437;
  localparam logic [StepW-1:0] ReleaseRst = 23'd218;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_ATTACK  = 2'd1,
    CFG_RELEASE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/ambisonic_auto_gain_compressor.sv =====
// a frame runs the level, gain, start, div, mul and push states to the output
// register; the next frame waits for the push, behind the bit-serial reciprocal
// (24 steps), the single multiplier reused over four channels and out_stall_i
// reset: gain 1.0, enable 1, attack 437, release 218, no result pending
// depends on aagc_pkg, aagc_recip, aagc_scale and assert_macros.svh
`include "assert_macros.svh"

module ambisonic_auto_gain_compressor (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // config write channel
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic        [aagc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic        [aagc_pkg::StepW-1:0]     cfg_data_i,
  // input frames
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [aagc_pkg::SmpW-1:0]      in_w_i,
  input  logic signed [aagc_pkg::SmpW-1:0]      in_x_i,
  input  logic signed [aagc_pkg::SmpW-1:0]      in_y_i,
  input  logic signed [aagc_pkg::SmpW-1:0]      in_z_i,
  // output frames
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [aagc_pkg::SmpW-1:0]      out_w_o,
  output logic signed [aagc_pkg::SmpW-1:0]      out_x_o,
  output logic signed [aagc_pkg::SmpW-1:0]      out_y_o,
  output logic signed [aagc_pkg::SmpW-1:0]      out_z_o
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LEVEL = 7'b0000010,
    ST_GAIN  = 7'b0000100,
    ST_START = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_MUL   = 7'b0100000,
    ST_PUSH  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic                              enable_q;
  logic [aagc_pkg::StepW-1:0]        attack_q;
  logic [aagc_pkg::StepW-1:0]        release_q;
  logic [aagc_pkg::GainW-1:0]        gain_q, gain_d;
  logic [aagc_pkg::GainW-1:0]        level_q, level_d;
  logic [1:0]                        ch_q, ch_d;
  logic                              out_valid_q, out_valid_d;

  logic signed [aagc_pkg::SmpW-1:0]  smp_q [4];
  logic signed [aagc_pkg::SmpW-1:0]  res_q [4];
  logic signed [aagc_pkg::SmpW-1:0]  out_q [4];

  logic                              in_acc;
  logic                              out_free;
  logic                              div_start;
  logic [aagc_pkg::GainW-1:0]        gain_clamped;
  aagc_pkg::div_stat_t               div_stat;
  logic [aagc_pkg::GainW-1:0]        recip;
  logic signed [aagc_pkg::SmpW-1:0]  scaled;

  logic [16:0]                       mag_w, mag_x, mag_y, mag_z, mag_max;
  logic [16:0]                       mag_sum;
  logic [aagc_pkg::GainW:0]          gain_up;
  logic [aagc_pkg::GainW-1:0]        gain_dist;

  function automatic logic [16:0] mag17(input logic signed [aagc_pkg::SmpW-1:0] s);
    logic [16:0] e;
    e = {s[aagc_pkg::SmpW-1], s};
    return s[aagc_pkg::SmpW-1] ? 17'(-e) : e;
  endfunction

  assign in_acc      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // ---------------- config registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b1;
      attack_q  <= aagc_pkg::AttackRst;
      release_q <= aagc_pkg::ReleaseRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_i)
        aagc_pkg::CFG_ENABLE:  enable_q  <= cfg_data_i[0];
        aagc_pkg::CFG_ATTACK:  attack_q  <= cfg_data_i;
        aagc_pkg::CFG_RELEASE: release_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- level estimate ----------------
  assign mag_w = mag17(smp_q[0]);
  assign mag_x = mag17(smp_q[1]);
  assign mag_y = mag17(smp_q[2]);
  assign mag_z = mag17(smp_q[3]);

  always_comb begin
    mag_max = mag_x;
    if (mag_y > mag_max) begin
      mag_max = mag_y;
    end
    if (mag_z > mag_max) begin
      mag_max = mag_z;
    end
  end

  // sum is at most 65536, so it fits 17 bits before the shift into q2.22
  assign mag_sum = mag_w + mag_max;
  assign level_d = enable_q ? {mag_sum, 7'b0} : aagc_pkg::OneQ22;

  // ---------------- attack / release tracking ----------------
  assign gain_up   = {1'b0, gain_q} + {2'b0, attack_q};
  assign gain_dist = gain_q - level_q;

  always_comb begin
    gain_d = gain_q;
    if (level_q > gain_q) begin
      gain_d = (gain_up > {1'b0, level_q}) ? level_q : gain_up[aagc_pkg::GainW-1:0];
    end else if (level_q < gain_q) begin
      gain_d = ({1'b0, release_q} >= gain_dist) ? level_q
                                                : gain_q - {1'b0, release_q};
    end
  end

  always_comb begin
    if (gain_q < aagc_pkg::GainMin) begin
      gain_clamped = aagc_pkg::GainMin;
    end else if (gain_q > aagc_pkg::GainMax) begin
      gain_clamped = aagc_pkg::GainMax;
    end else begin
      gain_clamped = gain_q;
    end
  end

  assign div_start = (state_q == ST_START);

  aagc_recip u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (gain_clamped),
    .stat_o    (div_stat),
    .quot_o    (recip)
  );

  aagc_scale u_scale (
    .smp_i   (smp_q[ch_q]),
    .recip_i (recip),
    .res_o   (scaled)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_LEVEL;
        end
      end
      ST_LEVEL: state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) begin
          state_d = ST_MUL;
          ch_d    = 2'd0;
        end
      end
      ST_MUL: begin
        ch_d = ch_q + 2'd1;
        if (ch_q == 2'd3) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // hold the finished frame until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
      gain_q      <= aagc_pkg::OneQ22;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_GAIN) begin
        gain_q <= gain_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      smp_q[0] <= in_w_i;
      smp_q[1] <= in_x_i;
      smp_q[2] <= in_y_i;
      smp_q[3] <= in_z_i;
    end
    if (state_q == ST_LEVEL) begin
      level_q <= level_d;
    end
    if (state_q == ST_MUL) begin
      res_q[ch_q] <= scaled;
    end
    if (state_q == ST_PUSH && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_w_o     = out_q[0];
  assign out_x_o     = out_q[1];
  assign out_y_o     = out_q[2];
  assign out_z_o     = out_q[3];

  // ---------------- assertions ----------------
  `AAGC_ASSERT(a_accept_starts_level, clk_i, rst_ni, in_acc |=> state_q == ST_LEVEL)
  `AAGC_ASSERT(a_div_done_in_div, clk_i, rst_ni, div_stat.done |-> state_q == ST_DIV)
  `AAGC_ASSERT(a_out_from_push, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == ST_PUSH)
  `AAGC_ASSERT(a_gain_in_range, clk_i, rst_ni, gain_q <= aagc_pkg::GainMax)
  `AAGC_ASSERT_NEVER(a_div_busy_idle, clk_i, rst_ni, div_stat.busy && state_q == ST_IDLE)

endmodule

// ===== hw/rtl/aagc_recip.sv =====
// iterative reciprocal unit: floor(2^44 / divisor), one quotient bit per cycle
// depends on aagc_pkg
module aagc_recip (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [aagc_pkg::GainW-1:0]    divisor_i,
  output aagc_pkg::div_stat_t           stat_o,
  output logic [aagc_pkg::GainW-1:0]    quot_o
);

  localparam int unsigned CntW = $clog2(aagc_pkg::DivSteps + 1);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [aagc_pkg::GainW-1:0] rem_q, rem_d;
  logic [aagc_pkg::GainW-1:0] quot_q, quot_d;
  logic [aagc_pkg::GainW-1:0] div_q;
  logic [aagc_pkg::GainW:0]   rem_sh;
  logic [aagc_pkg::GainW:0]   rem_sub;
  logic                       ge;

  // shared compare/subtract step of the restoring division
  assign rem_sh  = {rem_q, 1'b0};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(aagc_pkg::DivSteps);
      rem_d  = aagc_pkg::RemInit;
      quot_d = '0;
    end else if (busy_q) begin
      cnt_d  = cnt_q - CntW'(1);
      rem_d  = ge ? rem_sub[aagc_pkg::GainW-1:0] : rem_sh[aagc_pkg::GainW-1:0];
      quot_d = {quot_q[aagc_pkg::GainW-2:0], ge};
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

endmodule

// ===== hw/rtl/aagc_scale.sv =====
// shared sample scaler: floor(sample * recip / 2^22), saturated to 16 bits
// depends on aagc_pkg
module aagc_scale (
  input  logic signed [aagc_pkg::SmpW-1:0]  smp_i,
  input  logic        [aagc_pkg::GainW-1:0] recip_i,
  output logic signed [aagc_pkg::SmpW-1:0]  res_o
);

  localparam int unsigned ProdW = aagc_pkg::SmpW + aagc_pkg::GainW + 1;
  localparam int unsigned ShW   = ProdW - 22;

  logic signed [ProdW-1:0] prod;
  logic signed [ShW-1:0]   sh;

  assign prod = ProdW'(smp_i) * ProdW'($signed({1'b0, recip_i}));
  // arithmetic shift gives rounding toward minus infinity
  assign sh   = prod[ProdW-1:22];

  always_comb begin
    if (sh > ShW'(32767)) begin
      res_o = 16'sh7FFF;
    end else if (sh < -ShW'(32768)) begin
      res_o = 16'sh8000;
    end else begin
      res_o = sh[aagc_pkg::SmpW-1:0];
    end
  end

endmodule
